>>> sv/trm_pkg.sv
// Package for the threshold run merger: field widths, the queued run record
// and the divider state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package trm_pkg;

   localparam int POS_W   = 31;
   localparam int VAL_W   = 32;
   localparam int BASES_W = 32;
   localparam int SUM_W   = 64;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Register index decoded from paddr[2].
   localparam logic CSR_THRESHOLD_IDX = 1'b0;

   localparam logic signed [VAL_W-1:0] MEAN_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] MEAN_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef logic [$clog2(SUM_W)-1:0] div_count_type;

   // One closed run waiting for its mean.
   typedef struct packed {
      logic [POS_W-1:0]          run_start;
      logic [POS_W-1:0]          run_end;
      logic [BASES_W-1:0]        bases;
      logic signed [SUM_W-1:0]   sum;
   } run_rec_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage
`default_nettype wire

>>> sv/trm_front.sv
// Front end of the run merger: classifies intervals against the threshold,
// forms length * value and accumulates open runs. Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trm_front import trm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [VAL_W-1:0]  threshold,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [POS_W-1:0]         req_interval_start,
   input  logic [POS_W-1:0]         req_interval_end,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic                     req_last_in_chrom,
   input  logic                     queue_full,
   output logic                     push,
   output run_rec_type              push_rec
);

   // Stage one: classification and product.
   logic                     s1_valid_ff, s1_valid_in;
   logic [POS_W-1:0]         s1_start_ff, s1_end_ff, s1_size_ff;
   logic signed [SUM_W-1:0]  s1_prod_ff;
   logic                     s1_below_ff, s1_last_ff;

   // Stage two: the open run.
   logic                     open_ff, open_in;
   logic [POS_W-1:0]         ostart_ff, ostart_in, oend_ff, oend_in;
   logic [BASES_W-1:0]       bases_ff, bases_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   logic                     adv, step;
   logic [POS_W-1:0]         req_size;
   logic [POS_W-1:0]         new_start;
   logic [BASES_W-1:0]       base_bases, new_bases;
   logic [BASES_W:0]         bases_wide;
   logic signed [SUM_W-1:0]  base_sum, sum_raw, new_sum;

   assign adv       = !queue_full;
   assign req_stall = queue_full;
   assign step      = s1_valid_ff && adv;

   assign req_size = (req_interval_end > req_interval_start) ?
                     (req_interval_end - req_interval_start) : '0;

   assign s1_valid_in = adv ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_start_ff <= req_interval_start;
         s1_end_ff   <= req_interval_end;
         s1_size_ff  <= req_size;
         s1_prod_ff  <= SUM_W'(signed'({1'b0, req_size})) * SUM_W'(req_value);
         s1_below_ff <= (req_value < threshold);
         s1_last_ff  <= req_last_in_chrom;
      end
   end

   // A new run starts from zero; an open one continues.
   assign base_bases = open_ff ? bases_ff : '0;
   assign base_sum   = open_ff ? sum_ff : '0;
   assign new_start  = open_ff ? ostart_ff : s1_start_ff;

   assign bases_wide = {1'b0, base_bases} + (BASES_W + 1)'(s1_size_ff);
   assign new_bases  = bases_wide[BASES_W] ? {BASES_W{1'b1}} : bases_wide[BASES_W-1:0];

   // The product is never negative for a non-negative value, so overflow
   // shows as a sign change against two operands of equal sign.
   assign sum_raw = base_sum + s1_prod_ff;
   always_comb begin
      new_sum = sum_raw;
      if ((base_sum[SUM_W-1] == s1_prod_ff[SUM_W-1]) &&
          (sum_raw[SUM_W-1] != base_sum[SUM_W-1])) begin
         new_sum = base_sum[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
      end
   end

   always_comb begin
      open_in   = open_ff;
      ostart_in = ostart_ff;
      oend_in   = oend_ff;
      bases_in  = bases_ff;
      sum_in    = sum_ff;
      push      = 1'b0;
      push_rec  = '{run_start: ostart_ff, run_end: oend_ff, bases: bases_ff, sum: sum_ff};
      if (step) begin
         if (s1_below_ff) begin
            push    = open_ff;
            open_in = 1'b0;
         end else begin
            ostart_in = new_start;
            oend_in   = s1_end_ff;
            bases_in  = new_bases;
            sum_in    = new_sum;
            open_in   = !s1_last_ff;
            push      = s1_last_ff;
            push_rec  = '{run_start: new_start, run_end: s1_end_ff,
                          bases: new_bases, sum: new_sum};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      ostart_ff <= ostart_in;
      oend_ff   <= oend_in;
      bases_ff  <= bases_in;
      sum_ff    <= sum_in;
   end

endmodule
`default_nettype wire

>>> sv/trm_fifo.sv
// Short queue of closed runs between the front end and the divider.
// Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trm_fifo import trm_pkg::*; #(
   parameter int Depth = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  run_rec_type  push_rec,
   input  logic         pop,
   output run_rec_type  pop_rec,
   output logic         full,
   output logic         empty
);

   localparam int PW = $clog2(Depth);
   localparam int CW = $clog2(Depth + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

   run_rec_type      mem [Depth];
   run_rec_type      head_ff;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign pop_rec = head_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The head register tracks the next read slot; a record written into
   // that slot in the same cycle is forwarded straight into it.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_rec;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("run pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("run popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

>>> sv/trm_back.sv
// Back end of the run merger: a one-bit-per-cycle divider that forms the
// run mean, saturation, and the result register. Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trm_back import trm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  run_rec_type              pop_rec,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [POS_W-1:0]         rsp_run_start,
   output logic [POS_W-1:0]         rsp_run_end,
   output logic signed [VAL_W-1:0]  rsp_run_mean
);

   localparam div_count_type LAST_STEP = div_count_type'(SUM_W - 1);
   localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(64'h0000_0000_8000_0000);
   localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'(64'h0000_0000_7FFF_FFFF);

   back_state_type           state_ff, state_in;
   div_count_type            cnt_ff, cnt_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [BASES_W-1:0]       rem_ff, rem_in;
   logic [BASES_W-1:0]       dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic [POS_W-1:0]         start_ff, start_in, end_ff, end_in;

   logic                     out_valid_ff, out_valid_in;
   logic [POS_W-1:0]         out_start_ff, out_end_ff;
   logic signed [VAL_W-1:0]  out_mean_ff;
   logic                     load_out;
   logic signed [VAL_W-1:0]  mean;

   logic [BASES_W:0]         shifted, diff;
   logic [SUM_W-1:0]         mag;

   assign mag     = pop_rec.sum[SUM_W-1] ? -pop_rec.sum : pop_rec.sum;
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   // Truncated quotient magnitude in quo_ff; a zero divisor gives zero.
   always_comb begin
      if (dvs_ff == '0) begin
         mean = '0;
      end else if (neg_ff) begin
         mean = (quo_ff > NEG_LIMIT) ? MEAN_MIN : -signed'(quo_ff[VAL_W-1:0]);
      end else begin
         mean = (quo_ff > POS_LIMIT) ? MEAN_MAX : signed'(quo_ff[VAL_W-1:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      start_in = start_ff;
      end_in   = end_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               quo_in   = mag;
               rem_in   = '0;
               dvs_in   = pop_rec.bases;
               neg_in   = pop_rec.sum[SUM_W-1];
               start_in = pop_rec.run_start;
               end_in   = pop_rec.run_end;
               cnt_in   = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (!diff[BASES_W]) begin
               rem_in = diff[BASES_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[BASES_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      neg_ff   <= neg_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      if (load_out) begin
         out_start_ff <= start_ff;
         out_end_ff   <= end_ff;
         out_mean_ff  <= mean;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_run_start = out_start_ff;
   assign rsp_run_end   = out_end_ff;
   assign rsp_run_mean  = out_mean_ff;

`ifndef SYNTH
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && cnt_ff == LAST_STEP) |=> state_ff == BK_DONE)
      else $error("divider ran past its last step");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == BK_IDLE) else $error("queue popped while dividing");
   a_load_starts_idle: assert property (@(posedge clock) disable iff (reset)
      load_out |=> state_ff == BK_IDLE && out_valid_ff)
      else $error("result load lost");
`endif

endmodule
`default_nettype wire

>>> sv/threshold_run_merger_top.sv
// Threshold run merger, top level: configuration register, front end, run
// queue and divider back end. Depends on trm_pkg, trm_front, trm_fifo and
// trm_back.
// Throughput: the front end takes one interval per clock unless the run queue
//   is full; each closed run occupies the serial divider from its pop through
//   the quotient steps to the load of the result register.
// Reset: synchronous, clears threshold to zero, closes any open run and
//   empties the queue; the block is ready the cycle after reset falls.
`timescale 1ns / 1ps
`default_nettype none
module threshold_run_merger_top import trm_pkg::*; #(
   parameter int QueueDepth = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   // Interval words in.
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [POS_W-1:0]         req_interval_start,
   input  logic [POS_W-1:0]         req_interval_end,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic                     req_last_in_chrom,
   // Run words out.
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [POS_W-1:0]         rsp_run_start,
   output logic [POS_W-1:0]         rsp_run_end,
   output logic signed [VAL_W-1:0]  rsp_run_mean,
   // Register port.
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready
);

   // The threshold is the only register; it answers at byte addresses zero to
   // three (paddr[2] clear). Writes elsewhere are ignored and read back as zero.
   logic signed [VAL_W-1:0] threshold_ff, threshold_in;
   logic                    csr_write, csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == CSR_THRESHOLD_IDX);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   assign threshold_in = csr_write ? signed'(pwdata[VAL_W-1:0]) : threshold_ff;
   assign prdata       = csr_hit ? CSR_DW'(threshold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // The front end accumulates runs; each run it closes becomes one queued
   // record holding start, end, covered bases and the weighted sum.
   logic        queue_full, queue_empty, push, pop;
   run_rec_type push_rec, pop_rec;

   trm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .threshold          (threshold_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_interval_start (req_interval_start),
      .req_interval_end   (req_interval_end),
      .req_value          (req_value),
      .req_last_in_chrom  (req_last_in_chrom),
      .queue_full         (queue_full),
      .push               (push),
      .push_rec           (push_rec)
   );

   // The queue lets the front keep merging while the divider is busy.
   trm_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // The back end divides the sum by the bases and holds the result word
   // in its own output register until it is taken.
   trm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .pop_rec       (pop_rec),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_run_start (rsp_run_start),
      .rsp_run_end   (rsp_run_end),
      .rsp_run_mean  (rsp_run_mean)
   );

endmodule
`default_nettype wire

>>> bench/threshold_run_merger_top_tb.sv
// Testbench for threshold_run_merger_top: streams intervals in, checks every
// merged run word against a predictor kept in a small scoreboard class.
// Depends on trm_pkg and the threshold_run_merger_top RTL.
`timescale 1ns / 1ps
module threshold_run_merger_top_tb import trm_pkg::*; ();

   localparam int IDLE_LIMIT      = 4000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int STALL_PERIOD    = 300;

   localparam logic [POS_W-1:0]        POS_MAX = '1;
   localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [VAL_W-1:0] ZERO_Q16 = '0;
   localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_LO = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
   localparam logic [CSR_AW-1:0] THRESHOLD_ADDR = {CSR_THRESHOLD_IDX, 2'b00};

   typedef enum int {STALL_NONE, STALL_SPARSE, STALL_BURST, STALL_HEAVY} stall_mode_type;

   typedef struct {
      logic [POS_W-1:0]        run_start;
      logic [POS_W-1:0]        run_end;
      logic signed [VAL_W-1:0] run_mean;
   } run_word_type;

   // The scoreboard holds its own copy of the threshold and of the open run,
   // and queues the run words that the block owes us.
   class run_scoreboard;
      logic signed [VAL_W-1:0] threshold;
      bit                      run_open;
      logic [POS_W-1:0]        open_start;
      logic [POS_W-1:0]        open_end;
      logic [BASES_W-1:0]      covered_bases;
      longint                  weighted_sum;
      run_word_type            owed_runs[$];
      int                      mismatches;
      int                      runs_checked;

      function new();
         threshold    = '0;
         mismatches   = 0;
         runs_checked = 0;
         clear_run();
      endfunction

      function void clear_run();
         run_open      = 1'b0;
         open_start    = '0;
         open_end      = '0;
         covered_bases = '0;
         weighted_sum  = 0;
      endfunction

      // Mean truncates toward zero and is clamped to the Q16.16 range; a run
      // that covers no bases reports a mean of zero.
      function void close_run();
         longint       mean;
         run_word_type word;
         mean = 0;
         if (covered_bases != 0) begin
            mean = weighted_sum / longint'(covered_bases);
         end
         if (mean > longint'(MEAN_MAX)) begin
            mean = longint'(MEAN_MAX);
         end
         if (mean < longint'(MEAN_MIN)) begin
            mean = longint'(MEAN_MIN);
         end
         word.run_start = open_start;
         word.run_end   = open_end;
         word.run_mean  = mean[VAL_W-1:0];
         owed_runs.push_back(word);
         clear_run();
      endfunction

      function void note_interval(logic [POS_W-1:0] istart, logic [POS_W-1:0] iend,
                                  logic signed [VAL_W-1:0] ival, logic ilast);
         logic [BASES_W-1:0] bases;
         longint             weight;
         if (ival < threshold) begin
            if (run_open) begin
               close_run();
            end
            return;
         end
         bases = (iend > istart) ? BASES_W'(iend - istart) : '0;
         if (!run_open) begin
            run_open      = 1'b1;
            open_start    = istart;
            covered_bases = '0;
            weighted_sum  = 0;
         end
         open_end = iend;
         if (covered_bases > ~bases) begin
            covered_bases = '1;
         end else begin
            covered_bases = covered_bases + bases;
         end
         weight = longint'(bases) * longint'(ival);
         if (weight > 0 && weighted_sum > SUM_HI - weight) begin
            weighted_sum = SUM_HI;
         end else if (weight < 0 && weighted_sum < SUM_LO - weight) begin
            weighted_sum = SUM_LO;
         end else begin
            weighted_sum = weighted_sum + weight;
         end
         if (ilast) begin
            close_run();
         end
      endfunction

      function void check_run(logic [POS_W-1:0] rstart, logic [POS_W-1:0] rend,
                              logic signed [VAL_W-1:0] rmean);
         run_word_type want;
         if (owed_runs.size() == 0) begin
            $display("%0t: unexpected run word: start %0d end %0d mean %0d",
                     $time, rstart, rend, rmean);
            mismatches++;
            return;
         end
         want = owed_runs.pop_front();
         runs_checked++;
         if (rstart !== want.run_start) begin
            $display("%0t: run_start expected %0d, got %0d", $time, want.run_start, rstart);
            mismatches++;
         end
         if (rend !== want.run_end) begin
            $display("%0t: run_end expected %0d, got %0d", $time, want.run_end, rend);
            mismatches++;
         end
         if (rmean !== want.run_mean) begin
            $display("%0t: run_mean expected %0d, got %0d", $time, want.run_mean, rmean);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [POS_W-1:0]        req_interval_start = '0;
   logic [POS_W-1:0]        req_interval_end = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    req_last_in_chrom = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [POS_W-1:0]        rsp_run_start;
   logic [POS_W-1:0]        rsp_run_end;
   logic signed [VAL_W-1:0] rsp_run_mean;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_AW-1:0]       paddr = '0;
   logic [CSR_DW-1:0]       pwdata = '0;
   logic [CSR_DW-1:0]       prdata;
   logic                    pready;

   run_scoreboard    merged_runs;
   bit               req_fire;
   bit               rsp_fire;
   int               burst_left = 0;
   int               intervals_sent = 0;
   int               settings_written = 0;
   int               cycle_count = 0;
   int               stall_burst = 0;
   logic [POS_W-1:0] cursor = '0;

   threshold_run_merger_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_interval_start (req_interval_start),
      .req_interval_end   (req_interval_end),
      .req_value          (req_value),
      .req_last_in_chrom  (req_last_in_chrom),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_run_start      (rsp_run_start),
      .rsp_run_end        (rsp_run_end),
      .rsp_run_mean       (rsp_run_mean),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Handshakes are sampled at the falling edge, where every signal has
   // settled; a word seen valid and unstalled here moves at the next rising
   // edge. The watchdog reads these flags at that rising edge.
   always @(negedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (rsp_fire) begin
         merged_runs.check_run(rsp_run_start, rsp_run_end, rsp_run_mean);
      end
   end

   // The receiver cycles through four stall habits: none at all, sparse
   // single cycles, occasional long bursts, and mostly stalled.
   always @(posedge clock) begin
      stall_mode_type mode;
      mode = stall_mode_type'((cycle_count / STALL_PERIOD) % 4);
      cycle_count++;
      case (mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_SPARSE: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_BURST: begin
            if (stall_burst > 0) begin
               stall_burst--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 9) == 0) begin
                  stall_burst = $urandom_range(1, 24);
               end
            end
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // Ends the run when no word has moved on either channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (req_fire || rsp_fire) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // Sends one interval word. The sender works in bursts; when a burst is
   // used up it usually drops valid for a random gap before the next one.
   task automatic send_interval(input logic [POS_W-1:0] istart,
                                input logic [POS_W-1:0] iend,
                                input logic signed [VAL_W-1:0] ival,
                                input logic ilast);
      bit taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_interval_start <= istart;
      req_interval_end   <= iend;
      req_value          <= ival;
      req_last_in_chrom  <= ilast;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      merged_runs.note_interval(istart, iend, ival, ilast);
      intervals_sent++;
   endtask

   // Holds the sender off until every owed run word has come back, then
   // waits out the divider so the block is quiet.
   task automatic drain_and_pause();
      req_valid <= 1'b0;
      while (merged_runs.owed_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle held until pready.
   task automatic write_threshold(input logic signed [VAL_W-1:0] thr);
      bit ready;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= THRESHOLD_ADDR;
      pwdata  <= thr;
      @(posedge clock);
      penable <= 1'b1;
      ready = 1'b0;
      while (!ready) begin
         @(negedge clock);
         ready = pready;
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      merged_runs.threshold = thr;
      settings_written++;
   endtask

   // Values cluster around the threshold so that runs form and break often,
   // with some full-range values and the two extremes mixed in.
   function automatic logic signed [VAL_W-1:0] pick_value(logic signed [VAL_W-1:0] thr);
      longint v;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         v = longint'(thr) + longint'($urandom_range(0, 1 << 18));
      end else if (pick < 75) begin
         v = longint'(thr) - 1 - longint'($urandom_range(0, 1 << 18));
      end else if (pick < 87) begin
         v = longint'(thr) + longint'($urandom_range(0, 8)) - 4;
      end else if (pick < 95) begin
         v = longint'($signed($urandom()));
      end else begin
         v = ($urandom_range(0, 1) == 1) ? longint'(MEAN_MAX) : longint'(MEAN_MIN);
      end
      if (v > longint'(MEAN_MAX)) begin
         v = longint'(MEAN_MAX);
      end
      if (v < longint'(MEAN_MIN)) begin
         v = longint'(MEAN_MIN);
      end
      return v[VAL_W-1:0];
   endfunction

   // Mostly well-formed, ascending intervals with small gaps; a few huge
   // ones, a few with the end below the start, a few fully random.
   task automatic send_random_interval(input logic signed [VAL_W-1:0] thr);
      logic [POS_W-1:0] s;
      logic [POS_W-1:0] e;
      int               shape;
      shape = $urandom_range(0, 99);
      s = cursor + POS_W'($urandom_range(0, 50));
      if (shape < 80) begin
         e = s + POS_W'($urandom_range(0, 500));
      end else if (shape < 85) begin
         e = s + POS_W'($urandom());
      end else if (shape < 90) begin
         e = s - POS_W'($urandom_range(1, 300));
      end else begin
         s = POS_W'($urandom());
         e = POS_W'($urandom());
      end
      cursor = e;
      send_interval(s, e, pick_value(thr), $urandom_range(0, 14) == 0);
   endtask

   initial begin
      logic signed [VAL_W-1:0] thr;
      merged_runs = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset threshold of zero. A value equal to the
      // threshold counts as covered; the chromosome end closes the run.
      send_interval(0, 10, ZERO_Q16, 1'b1);
      send_interval(20, 30, -1, 1'b0);            // below, nothing open
      send_interval(100, 50, 5, 1'b0);            // end below start opens run
      send_interval(200, 200, MEAN_MAX, 1'b1);    // zero bases, mean is zero
      // Three full-length intervals at the top value saturate both
      // accumulators, and the clamped mean comes out at the top.
      send_interval(0, POS_MAX, MEAN_MAX, 1'b0);
      send_interval(0, POS_MAX, MEAN_MAX, 1'b0);
      send_interval(0, POS_MAX, MEAN_MAX, 1'b0);
      send_interval(5, 6, -1, 1'b0);              // below threshold closes
      send_interval(7, 9, -5, 1'b1);              // last and below, no run
      send_interval(10, 20, 3 * ONE_Q16, 1'b0);
      send_interval(30, 40, ONE_Q16, 1'b0);       // gap does not break it
      send_interval(45, 47, MEAN_MIN, 1'b1);      // last below emits once
      send_interval(POS_MAX, 0, 1, 1'b1);
      drain_and_pause();

      // Lowest threshold: the most negative values saturate the sum low.
      write_threshold(MEAN_MIN);
      send_interval(0, POS_MAX, MEAN_MIN, 1'b0);
      send_interval(0, POS_MAX, MEAN_MIN, 1'b0);
      send_interval(0, POS_MAX, MEAN_MIN, 1'b1);
      send_interval(3, 9, -7 * ONE_Q16, 1'b1);
      drain_and_pause();

      // Highest threshold: only the top value is covered.
      write_threshold(MEAN_MAX);
      send_interval(1, 4, MEAN_MAX, 1'b0);
      send_interval(6, 9, MEAN_MAX - 1, 1'b0);
      send_interval(10, 12, MEAN_MAX, 1'b0);
      send_interval(13, 15, MEAN_MAX, 1'b1);

      // Random phases, each under its own threshold setting. Every phase
      // starts with the sender held off until all owed runs are back.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_and_pause();
         case (phase % 6)
            0: thr = $signed($urandom_range(0, 1 << 17)) - ONE_Q16;
            1: thr = MEAN_MIN;
            2: thr = MEAN_MAX;
            3: thr = ONE_Q16;
            4: thr = -2 * ONE_Q16;
            default: thr = $signed($urandom());
         endcase
         write_threshold(thr);
         repeat (ITEMS_PER_PHASE) send_random_interval(thr);
      end
      drain_and_pause();

      $display("Summary: %0d intervals sent, %0d runs compared, %0d threshold settings.",
               intervals_sent, merged_runs.runs_checked, settings_written);
      $display("Included zero-length runs, saturated sums and bursty flow on both sides.");
      if (merged_runs.mismatches == 0 && merged_runs.owed_runs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
